// ===== hdl/tf256_pkg.sv =====
`default_nettype none

package tf256_pkg;

    localparam int WORD_W    = 64;
    localparam int NUM_KEYS  = 5;
    localparam int NUM_CELLS = 91;          // 19 subkey cells and 72 round cells

    localparam logic [WORD_W-1:0] KS_PARITY = 64'h5555_5555_5555_5555;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [NUM_KEYS-1:0] key_t;

    // one block in flight
    typedef struct packed {
        logic           kind;               // 0 encrypt, 1 decrypt
        word_t [3:0]    v;
        word_t          t0;
        word_t          t1;
    } item_t;

    // fixed role of one cell, separate settings for each direction
    typedef struct packed {
        logic                   inject;     // subkey cell when set, round cell otherwise
        logic [5:0]             rot_e0;
        logic [5:0]             rot_e1;
        logic [5:0]             rot_d0;
        logic [5:0]             rot_d1;
        logic [3:0][2:0]        key_e;      // key word index per block word
        logic [1:0][1:0]        tw_e;       // tweak word index for block words 1 and 2
        logic [4:0]             sub_e;      // subkey number
        logic [3:0][2:0]        key_d;
        logic [1:0][1:0]        tw_d;
        logic [4:0]             sub_d;
    } cell_cfg_t;

    localparam logic [5:0] ROT0 [8] = '{6'd14, 6'd52, 6'd23, 6'd5, 6'd25, 6'd46, 6'd58, 6'd32};
    localparam logic [5:0] ROT1 [8] = '{6'd16, 6'd57, 6'd40, 6'd37, 6'd33, 6'd12, 6'd22, 6'd32};

    // g: group of five cells, m: place in the group (0 is the subkey cell)
    function automatic cell_cfg_t cell_cfg(input int g, input int m);
        cell_cfg_t c;
        int        se;
        int        sd;
        int        de;
        int        dd;
        c  = '0;
        se = g;
        sd = 18 - g;
        de = 4 * g + m - 1;
        dd = 71 - de;
        c.inject = (m == 0);
        if (m != 0)
        begin
            c.rot_e0 = ROT0[de % 8];
            c.rot_e1 = ROT1[de % 8];
            c.rot_d0 = ROT0[dd % 8];
            c.rot_d1 = ROT1[dd % 8];
        end
        for (int i = 0; i < 4; i++)
        begin
            c.key_e[i] = 3'((se + i) % 5);
            c.key_d[i] = 3'((sd + i) % 5);
        end
        c.tw_e[0] = 2'(se % 3);
        c.tw_e[1] = 2'((se + 1) % 3);
        c.tw_d[0] = 2'(sd % 3);
        c.tw_d[1] = 2'((sd + 1) % 3);
        c.sub_e   = 5'(se);
        c.sub_d   = 5'(sd);
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tf256_cell.sv =====
`default_nettype none

module tf256_cell (
    input  wire                   clk,
    input  wire                   rst_n,
    input  tf256_pkg::cell_cfg_t  cfg,
    input  tf256_pkg::key_t       keys,
    input  wire                   in_valid,
    input  tf256_pkg::item_t      in_item,
    output logic                  in_ready,
    output logic                  out_valid,
    output tf256_pkg::item_t      out_item,
    input  wire                   out_ready
);
    import tf256_pkg::*;

    logic            valid_reg;
    item_t           item_reg;
    item_t           item_next;

    logic [3:0][2:0] kidx;
    logic [1:0][1:0] tidx;
    logic [4:0]      sidx;
    logic [5:0]      r0;
    logic [5:0]      r1;
    word_t           t2;
    word_t [3:0]     kw;
    word_t [3:0]     tadd;
    word_t           y0;
    word_t           y1;
    word_t           y2;
    word_t           y3;

    function automatic word_t rotl(input word_t x, input logic [5:0] r);
        return (x << r) | (x >> (7'd64 - {1'b0, r}));
    endfunction

    function automatic word_t rotr(input word_t x, input logic [5:0] r);
        return (x >> r) | (x << (7'd64 - {1'b0, r}));
    endfunction

    function automatic word_t key_sel(input key_t k, input logic [2:0] idx);
        word_t w;
        case (idx)
            3'd1:    w = k[1];
            3'd2:    w = k[2];
            3'd3:    w = k[3];
            3'd4:    w = k[4];
            default: w = k[0];
        endcase
        return w;
    endfunction

    function automatic word_t tw_sel(input word_t a, input word_t b, input word_t c,
                                     input logic [1:0] idx);
        word_t w;
        case (idx)
            2'd1:    w = b;
            2'd2:    w = c;
            default: w = a;
        endcase
        return w;
    endfunction

    always_comb
    begin
        kidx = in_item.kind ? cfg.key_d : cfg.key_e;
        tidx = in_item.kind ? cfg.tw_d  : cfg.tw_e;
        sidx = in_item.kind ? cfg.sub_d : cfg.sub_e;
        r0   = in_item.kind ? cfg.rot_d0 : cfg.rot_e0;
        r1   = in_item.kind ? cfg.rot_d1 : cfg.rot_e1;
        t2   = in_item.t0 ^ in_item.t1;
        for (int i = 0; i < 4; i++)
        begin
            kw[i] = key_sel(keys, kidx[i]);
        end
        tadd[0] = '0;
        tadd[1] = tw_sel(in_item.t0, in_item.t1, t2, tidx[0]);
        tadd[2] = tw_sel(in_item.t0, in_item.t1, t2, tidx[1]);
        tadd[3] = {{(WORD_W-5){1'b0}}, sidx};
    end

    always_comb
    begin
        item_next = in_item;
        y0 = '0;
        y1 = '0;
        y2 = '0;
        y3 = '0;
        if (cfg.inject)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (in_item.kind)
                begin
                    item_next.v[i] = in_item.v[i] - kw[i] - tadd[i];
                end
                else
                begin
                    item_next.v[i] = in_item.v[i] + kw[i] + tadd[i];
                end
            end
        end
        else if (!in_item.kind)
        begin
            y0 = in_item.v[0] + in_item.v[1];
            y1 = rotl(in_item.v[1], r0) ^ y0;
            y2 = in_item.v[2] + in_item.v[3];
            y3 = rotl(in_item.v[3], r1) ^ y2;
            item_next.v[0] = y0;
            item_next.v[1] = y3;
            item_next.v[2] = y2;
            item_next.v[3] = y1;
        end
        else
        begin
            // undo the word swap, then each mix
            y1 = rotr(in_item.v[3] ^ in_item.v[0], r0);
            y3 = rotr(in_item.v[1] ^ in_item.v[2], r1);
            item_next.v[0] = in_item.v[0] - y1;
            item_next.v[1] = y1;
            item_next.v[2] = in_item.v[2] - y3;
            item_next.v[3] = y3;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/threefish256_block_cipher.sv =====
// Threefish-256 tweakable block cipher, fully pipelined.
//
// Input stream (s_axis): one block per transfer. tdata carries the four data
// words and the two tweak words, tuser bit 0 selects encrypt (0) or decrypt (1).
// Output stream (m_axis): the four result words, one transfer per input block,
// in input order.
// Key: four 64-bit words written through cfg_we / cfg_index / cfg_wdata; write
// them only while no block is in flight.
// The datapath is a row of 91 cells, one per subkey injection or round, each
// with its own register. A result shows on m_axis once it has passed through
// the register of every cell in order; one block is accepted every cycle
// while s_axis_tready is high.
// When the receiver stalls, the result holds in the last cell and cells fill
// up behind it; the input keeps taking blocks while any cell down the row is
// empty, so ready drops only once the whole row is full.
// Reset clears the key to zero and empties all cells.
`default_nettype none

module threefish256_block_cipher (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          cfg_we,
    input  wire  [1:0]   cfg_index,
    input  wire  [63:0]  cfg_wdata,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // data_in0, data_in1, data_in2, data_in3, tweak_lo, tweak_hi
    input  wire  [383:0] s_axis_tdata,
    // kind
    input  wire  [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // data_out0, data_out1, data_out2, data_out3
    output logic [255:0] m_axis_tdata
);
    import tf256_pkg::*;

    word_t [3:0] key_reg;
    key_t        keys;

    logic        pipe_valid [NUM_CELLS+1];
    logic        pipe_ready [NUM_CELLS+1];
    item_t       pipe_item  [NUM_CELLS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_we)
        begin
            key_reg[cfg_index] <= cfg_wdata;
        end
    end

    assign keys[0] = key_reg[0];
    assign keys[1] = key_reg[1];
    assign keys[2] = key_reg[2];
    assign keys[3] = key_reg[3];
    assign keys[4] = KS_PARITY ^ key_reg[0] ^ key_reg[1] ^ key_reg[2] ^ key_reg[3];

    assign pipe_valid[0]     = s_axis_tvalid;
    assign pipe_item[0].kind = s_axis_tuser[0];
    assign pipe_item[0].v[0] = s_axis_tdata[63:0];
    assign pipe_item[0].v[1] = s_axis_tdata[127:64];
    assign pipe_item[0].v[2] = s_axis_tdata[191:128];
    assign pipe_item[0].v[3] = s_axis_tdata[255:192];
    assign pipe_item[0].t0   = s_axis_tdata[319:256];
    assign pipe_item[0].t1   = s_axis_tdata[383:320];
    assign s_axis_tready     = pipe_ready[0];

    for (genvar j = 0; j < NUM_CELLS; j++)
    begin : g_cell
        localparam int G = j / 5;
        localparam int M = j % 5;
        localparam cell_cfg_t CFG = cell_cfg(G, M);

        tf256_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg       (CFG),
            .keys      (keys),
            .in_valid  (pipe_valid[j]),
            .in_item   (pipe_item[j]),
            .in_ready  (pipe_ready[j]),
            .out_valid (pipe_valid[j+1]),
            .out_item  (pipe_item[j+1]),
            .out_ready (pipe_ready[j+1])
        );
    end

    assign pipe_ready[NUM_CELLS] = m_axis_tready;
    assign m_axis_tvalid         = pipe_valid[NUM_CELLS];
    assign m_axis_tdata          = {pipe_item[NUM_CELLS].v[3], pipe_item[NUM_CELLS].v[2],
                                    pipe_item[NUM_CELLS].v[1], pipe_item[NUM_CELLS].v[0]};

endmodule

`default_nettype wire
